/* hw/rtl/hsv_pkg.sv */
// ---------------------------------------------------------------------------
// HSV to RGB package
// Shared constants and control types for the HSV to RGB pipeline.
// ---------------------------------------------------------------------------
package hsv_pkg;

  // Default number of fractional bits; a value of 2**FRAC_BITS means 1.0.
  localparam int FRAC_BITS_DEF = 16;

  // Color wheel sectors, each one sixth of a turn.
  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;

  // Control that travels alongside the data of one request.
  typedef struct packed {
    logic       valid;
    logic       gray;
    logic [2:0] sector;
  } hsv_ctl_t;

endpackage

/* hw/rtl/hsv_prep.sv */
// ---------------------------------------------------------------------------
// HSV input stage
// Wraps the hue, clamps saturation and brightness, and splits the scaled
// hue into a sector number and a fraction.
// ---------------------------------------------------------------------------
module hsv_prep #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [FRAC_BITS:0]     hue,
  input  logic [FRAC_BITS:0]     saturation,
  input  logic [FRAC_BITS:0]     brightness,
  output hsv_pkg::hsv_ctl_t      ctl,
  output logic [FRAC_BITS:0]     sat,
  output logic [FRAC_BITS:0]     val,
  output logic [FRAC_BITS-1:0]   frac
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic [FRAC_BITS-1:0] hue_wrap;
  logic [FRAC_BITS+2:0] scaled;
  logic [W-1:0]         sat_next;
  logic [W-1:0]         val_next;

  // A full turn and anything above it wrap: only the fraction bits count.
  assign hue_wrap = hue[FRAC_BITS-1:0];
  // Times six as a shift-add.
  assign scaled   = ((FRAC_BITS+3)'(hue_wrap) << 2) + ((FRAC_BITS+3)'(hue_wrap) << 1);
  assign sat_next = (saturation > ONE) ? ONE : saturation;
  assign val_next = (brightness > ONE) ? ONE : brightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= start;
    end
    ctl.gray   <= (sat_next == '0);
    ctl.sector <= scaled[FRAC_BITS+2:FRAC_BITS];
    sat        <= sat_next;
    val        <= val_next;
    frac       <= scaled[FRAC_BITS-1:0];
  end

endmodule

/* hw/rtl/hsv_mult.sv */
// ---------------------------------------------------------------------------
// HSV product stages
// Two multiplier stages that form p, q and t with truncating products.
// ---------------------------------------------------------------------------
module hsv_mult #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hsv_pkg::hsv_ctl_t      ctl_in,
  input  logic [FRAC_BITS:0]     sat,
  input  logic [FRAC_BITS:0]     val_in,
  input  logic [FRAC_BITS-1:0]   frac,
  output hsv_pkg::hsv_ctl_t      ctl_out,
  output logic [FRAC_BITS:0]     val_out,
  output logic [FRAC_BITS:0]     p_out,
  output logic [FRAC_BITS:0]     q_out,
  output logic [FRAC_BITS:0]     t_out
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  // First product stage: s*f, s*(1-f) and v*(1-s).
  logic [2*W-1:0]    prod_sf;
  logic [2*W-1:0]    prod_sg;
  logic [2*W-1:0]    prod_p;
  hsv_pkg::hsv_ctl_t ctl_mid;
  logic [W-1:0]      val_mid;
  logic [W-1:0]      p_mid;
  logic [W-1:0]      one_sf;
  logic [W-1:0]      one_sg;

  assign prod_sf = (2*W)'(sat) * (2*W)'(frac);
  assign prod_sg = (2*W)'(sat) * (2*W)'(ONE - W'(frac));
  assign prod_p  = (2*W)'(val_in) * (2*W)'(ONE - sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid.valid <= 1'b0;
    end else begin
      ctl_mid.valid <= ctl_in.valid;
    end
    ctl_mid.gray   <= ctl_in.gray;
    ctl_mid.sector <= ctl_in.sector;
    val_mid        <= val_in;
    p_mid          <= prod_p[FRAC_BITS+W-1:FRAC_BITS];
    one_sf         <= ONE - prod_sf[FRAC_BITS+W-1:FRAC_BITS];
    one_sg         <= ONE - prod_sg[FRAC_BITS+W-1:FRAC_BITS];
  end

  // Second product stage: q = v*(1-s*f), t = v*(1-s*(1-f)).
  logic [2*W-1:0] prod_q;
  logic [2*W-1:0] prod_t;

  assign prod_q = (2*W)'(val_mid) * (2*W)'(one_sf);
  assign prod_t = (2*W)'(val_mid) * (2*W)'(one_sg);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_mid.valid;
    end
    ctl_out.gray   <= ctl_mid.gray;
    ctl_out.sector <= ctl_mid.sector;
    val_out        <= val_mid;
    p_out          <= p_mid;
    q_out          <= prod_q[FRAC_BITS+W-1:FRAC_BITS];
    t_out          <= prod_t[FRAC_BITS+W-1:FRAC_BITS];
  end

endmodule

/* hw/rtl/hsv_select.sv */
// ---------------------------------------------------------------------------
// HSV output stage
// Routes v, p, q and t to red, green and blue by sector and registers them.
// ---------------------------------------------------------------------------
module hsv_select #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hsv_pkg::hsv_ctl_t      ctl,
  input  logic [FRAC_BITS:0]     val,
  input  logic [FRAC_BITS:0]     p,
  input  logic [FRAC_BITS:0]     q,
  input  logic [FRAC_BITS:0]     t,
  output logic                   done,
  output logic [FRAC_BITS:0]     red,
  output logic [FRAC_BITS:0]     green,
  output logic [FRAC_BITS:0]     blue
);

  logic [FRAC_BITS:0] red_next;
  logic [FRAC_BITS:0] green_next;
  logic [FRAC_BITS:0] blue_next;

  always_comb begin
    if (ctl.gray) begin
      red_next   = val;
      green_next = val;
      blue_next  = val;
    end else begin
      unique case (ctl.sector)
        hsv_pkg::SECTOR_0: begin
          red_next = val; green_next = t;   blue_next = p;
        end
        hsv_pkg::SECTOR_1: begin
          red_next = q;   green_next = val; blue_next = p;
        end
        hsv_pkg::SECTOR_2: begin
          red_next = p;   green_next = val; blue_next = t;
        end
        hsv_pkg::SECTOR_3: begin
          red_next = p;   green_next = q;   blue_next = val;
        end
        hsv_pkg::SECTOR_4: begin
          red_next = t;   green_next = p;   blue_next = val;
        end
        default: begin
          red_next = val; green_next = p;   blue_next = q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

/* hw/rtl/hsv_to_rgb_converter_top.sv */
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Fixed-point pixel converter from hue, saturation and brightness to RGB.
// ---------------------------------------------------------------------------
// A request is accepted at a rising clock edge where start is high and busy
// is low. Busy is always low: the block is a four-stage pipeline and takes a
// new pixel on every clock, so a stream runs at one pixel per cycle.
//
// Hue is a fraction of a full turn; its upper bit is ignored, so a full turn
// reads as zero. Saturation and brightness above 1.0 are clamped to 1.0.
// Zero saturation gives gray, all three outputs equal to the brightness.
//
// A request passes through the prep, mid-product, product and output
// registers in that order and then appears on red, green and blue with done
// high. Each result is shown for exactly one cycle; the receiver cannot
// stall the pipeline, so it must capture it then.
//
// The stages are: wrap and clamp with hue times six, the products s*f,
// s*(1-f) and v*(1-s), the products v*(1-s*f) and v*(1-s*(1-f)), and the
// sector select into the output registers. Every product truncates.
//
// Synchronous reset clears the valid bits of all stages; requests in flight
// are dropped and no done strobe follows them.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_top #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FRAC_BITS:0] hue,
  input  logic [FRAC_BITS:0] saturation,
  input  logic [FRAC_BITS:0] brightness,
  output logic               done,
  output logic [FRAC_BITS:0] red,
  output logic [FRAC_BITS:0] green,
  output logic [FRAC_BITS:0] blue
);

  hsv_pkg::hsv_ctl_t    prep_ctl;
  logic [FRAC_BITS:0]   prep_sat;
  logic [FRAC_BITS:0]   prep_val;
  logic [FRAC_BITS-1:0] prep_frac;

  hsv_pkg::hsv_ctl_t    mult_ctl;
  logic [FRAC_BITS:0]   mult_val;
  logic [FRAC_BITS:0]   mult_p;
  logic [FRAC_BITS:0]   mult_q;
  logic [FRAC_BITS:0]   mult_t;

  // The pipeline never refuses a request.
  assign busy = 1'b0;

  hsv_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .ctl        (prep_ctl),
    .sat        (prep_sat),
    .val        (prep_val),
    .frac       (prep_frac)
  );

  hsv_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (prep_ctl),
    .sat     (prep_sat),
    .val_in  (prep_val),
    .frac    (prep_frac),
    .ctl_out (mult_ctl),
    .val_out (mult_val),
    .p_out   (mult_p),
    .q_out   (mult_q),
    .t_out   (mult_t)
  );

  hsv_select #(.FRAC_BITS(FRAC_BITS)) u_select (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mult_ctl),
    .val   (mult_val),
    .p     (mult_p),
    .q     (mult_q),
    .t     (mult_t),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  // Every done strobe traces back to a request.
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("done without a matching request");

  // A request with no reset in flight always yields a done strobe.
  a_request_gives_done: assert property (@(posedge clk)
    ($past(start, 4) && !rst && !$past(rst, 1) && !$past(rst, 2) &&
     !$past(rst, 3) && !$past(rst, 4)) |-> done)
    else $error("request lost in the pipeline");

  // Zero saturation must come out gray.
  a_gray_output: assert property (@(posedge clk) disable iff (rst)
    (done && $past(saturation, 4) == '0) |-> (red == green && green == blue))
    else $error("gray pixel produced unequal components");

  // No component of a result exceeds the brightness it came from, when that brightness is at most 1.0.
  a_not_above_value: assert property (@(posedge clk) disable iff (rst)
    (done && $past(brightness, 4) <= (FRAC_BITS+1)'(1) << FRAC_BITS) |->
      (red <= $past(brightness, 4) && green <= $past(brightness, 4) &&
       blue <= $past(brightness, 4)))
    else $error("component above brightness");

endmodule
